// File: src/fstc_pkg.sv
// Package for the flow statistics table classifier: sizes, codes, beat and
// record types, and the decision-tree label function. No dependencies.
package fstc_pkg;

  localparam int ENTRIES = 1024;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;

  localparam logic [15:0] BIG_TINY_LO  = 16'd5;
  localparam logic [15:0] BIG_TINY_HI  = 16'd7;
  localparam logic [15:0] SMALL_TINY   = 16'd4;
  localparam logic [15:0] SMALL_LIMIT  = 16'd12;
  localparam logic [15:0] SMALL_FLOOR  = 16'd1;
  localparam logic [15:0] BIG_LARGE    = 16'd4379;
  localparam logic [15:0] BIG_SHORT    = 16'd14;
  localparam logic [63:0] GAP_SHORT    = 64'd99;
  localparam logic [63:0] GAP_LONG     = 64'd469570;

  typedef enum logic [1:0] {
    ST_IGNORED  = 2'd0,
    ST_UPDATED  = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] ether_type;
    logic        truncated;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [15:0] packet_length;
    logic [63:0] arrival_time;
  } item_t;

  typedef struct packed {
    logic [15:0] big;
    logic [15:0] sec;
    logic [15:0] small_sz;
    logic [63:0] last_time;
    logic [63:0] max_gap;
    logic [31:0] packets;
    logic [31:0] bytes;
    logic        label;
  } rec_t;

  typedef struct packed {
    status_t     status;
    logic        flow_flag;
    logic [31:0] packet_count;
    logic [31:0] byte_count;
    logic [15:0] largest_size;
    logic [15:0] second_largest_size;
    logic [15:0] smallest_size;
    logic [63:0] longest_gap;
  } result_t;

  typedef struct packed {
    logic latch_in;
    logic scan_start;
    logic scan_step;
    logic rec_read;
    logic modify;
    logic commit;
    logic insert;
    logic set_ignore;
    logic set_full;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic counted;
    logic hit;
    logic miss;
    logic full;
    logic out_free;
  } stat_t;

  function automatic logic tree_label(input logic [15:0] big, input logic [15:0] small_sz,
                                      input logic [63:0] gap);
    logic a, b, c;
    a = (small_sz <= SMALL_TINY) && (big <= BIG_TINY_HI) && (big > BIG_TINY_LO);
    b = (small_sz <= SMALL_LIMIT) && (gap > GAP_SHORT) && (big > BIG_LARGE);
    c = (small_sz <= SMALL_LIMIT) && (small_sz > SMALL_FLOOR) && (gap > GAP_LONG)
        && (big <= BIG_SHORT);
    return a | b | c;
  endfunction

  function automatic result_t rec_result(input status_t st, input rec_t r);
    result_t o;
    o.status              = st;
    o.flow_flag           = r.label;
    o.packet_count        = r.packets;
    o.byte_count          = r.bytes;
    o.largest_size        = r.big;
    o.second_largest_size = r.sec;
    o.smallest_size       = r.small_sz;
    o.longest_gap         = r.max_gap;
    return o;
  endfunction

endpackage

// File: src/fstc_ctrl.sv
// Controller state machine of the flow statistics table classifier.
// Depends on fstc_pkg for command and status types.
module fstc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fstc_pkg::stat_t stat,
  output fstc_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {S_IDLE, S_CLASSIFY, S_SCAN, S_MODIFY, S_COMMIT, S_EMIT} state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in   = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        if (!stat.counted) begin
          cmd.set_ignore = 1'b1;
          state_next     = S_EMIT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.rec_read = 1'b1;
          state_next   = S_MODIFY;
        end else if (stat.miss) begin
          if (stat.full) cmd.set_full = 1'b1;
          else cmd.insert = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_MODIFY: begin
        cmd.modify = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

// File: src/fstc_datapath.sv
// Datapath of the flow statistics table classifier: key and record memories,
// fill count, scan pointer, record update and output register. Uses fstc_pkg.
module fstc_datapath (
  input  logic              clk,
  input  logic              rst,
  input  fstc_pkg::item_t   item,
  input  fstc_pkg::cmd_t    cmd,
  output fstc_pkg::stat_t   stat,
  output logic              out_valid,
  input  logic              out_ready,
  output fstc_pkg::result_t out_res
);

  logic [31:0]         key_mem [fstc_pkg::ENTRIES];
  fstc_pkg::rec_t      rec_mem [fstc_pkg::ENTRIES];

  fstc_pkg::item_t     in_q;
  logic [fstc_pkg::CNT_W-1:0] occ;
  logic [fstc_pkg::CNT_W-1:0] scan_idx;
  logic [31:0]         key_q;
  logic [fstc_pkg::IDX_W-1:0] key_idx;
  logic                key_vld;
  fstc_pkg::rec_t      rec_q;
  fstc_pkg::rec_t      upd_q;
  fstc_pkg::rec_t      upd;
  fstc_pkg::rec_t      init_rec;
  logic [fstc_pkg::IDX_W-1:0] slot_q;
  fstc_pkg::result_t   res;

  assign stat.counted  = (in_q.ether_type == fstc_pkg::ETH_IPV4) && !in_q.truncated
                         && (in_q.ip_protocol == fstc_pkg::PROTO_ICMP);
  assign stat.hit      = key_vld && (key_q == in_q.source_address);
  assign stat.miss     = !key_vld && (scan_idx == occ);
  assign stat.full     = (occ == fstc_pkg::CNT_W'(fstc_pkg::ENTRIES));
  assign stat.out_free = !out_valid || out_ready;

  always_comb begin
    init_rec.big       = in_q.packet_length;
    init_rec.sec       = in_q.packet_length;
    init_rec.small_sz  = in_q.packet_length;
    init_rec.last_time = in_q.arrival_time;
    init_rec.max_gap   = '0;
    init_rec.packets   = 32'd1;
    init_rec.bytes     = {16'd0, in_q.packet_length};
    init_rec.label     = 1'b0;
  end

  // Size chain, gap and counts of a known flow.
  always_comb begin
    logic [15:0] len;
    logic [63:0] gap;
    len = in_q.packet_length;
    gap = in_q.arrival_time - rec_q.last_time;
    upd = rec_q;
    if (len > rec_q.big) begin
      upd.sec = rec_q.big;
      upd.big = len;
    end else if (len > rec_q.sec && len != rec_q.big) begin
      upd.sec = len;
    end else if (len < rec_q.small_sz) begin
      upd.small_sz = len;
    end
    if (gap > rec_q.max_gap) upd.max_gap = gap;
    upd.last_time = in_q.arrival_time;
    upd.packets   = rec_q.packets + 32'd1;
    upd.bytes     = rec_q.bytes + {16'd0, len};
    upd.label     = rec_q.label | fstc_pkg::tree_label(upd.big, upd.small_sz, upd.max_gap);
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) in_q <= item;
    if (cmd.scan_step && (scan_idx < occ)) begin
      key_q   <= key_mem[scan_idx[fstc_pkg::IDX_W-1:0]];
      key_idx <= scan_idx[fstc_pkg::IDX_W-1:0];
    end
    if (cmd.rec_read) begin
      rec_q  <= rec_mem[key_idx];
      slot_q <= key_idx;
    end
    if (cmd.modify) upd_q <= upd;
    if (cmd.commit) begin
      rec_mem[slot_q] <= upd_q;
      res             <= fstc_pkg::rec_result(fstc_pkg::ST_UPDATED, upd_q);
    end
    if (cmd.insert) begin
      key_mem[occ[fstc_pkg::IDX_W-1:0]] <= in_q.source_address;
      rec_mem[occ[fstc_pkg::IDX_W-1:0]] <= init_rec;
      res <= fstc_pkg::rec_result(fstc_pkg::ST_INSERTED, init_rec);
    end
    if (cmd.set_ignore) res <= fstc_pkg::rec_result(fstc_pkg::ST_IGNORED, '0);
    if (cmd.set_full) res <= fstc_pkg::rec_result(fstc_pkg::ST_FULL, '0);
    if (cmd.load_out) out_res <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      scan_idx  <= '0;
      key_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.insert) occ <= occ + fstc_pkg::CNT_W'(1);
      if (cmd.scan_start) begin
        scan_idx <= '0;
        key_vld  <= 1'b0;
      end else if (cmd.scan_step) begin
        if (scan_idx < occ) begin
          scan_idx <= scan_idx + fstc_pkg::CNT_W'(1);
          key_vld  <= 1'b1;
        end else begin
          key_vld <= 1'b0;
        end
      end
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= fstc_pkg::CNT_W'(fstc_pkg::ENTRIES))
    else $error("fill count beyond table size");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !stat.full)
    else $error("insert into a full table");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scan_idx <= occ)
    else $error("scan pointer past the filled slots");

endmodule

// File: src/flow_stats_table_classifier.sv
// Top level of the flow statistics table classifier: stream ports, controller
// and datapath. Depends on fstc_pkg, fstc_ctrl and fstc_datapath.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | packet event, truncated in s_tuser
//  m_*     | out | m_tvalid/m_tready  | flow result, status in m_tuser
//
// Steps, accept to next accept: an ignored packet passes classify and emit; a
// counted packet that matches slot k scans slots 0 to k, then modify, commit
// and emit; a new source or a full table scans all N filled slots, then emit.
// The time is set by the linear key scan, one key-memory read per cycle
// over the filled slots.
// Reset: rst clears the fill count, so the table starts empty at once.
// Stalls: one result register parts the sides; the next beat is taken while
// a result still waits, and the block holds in its emit step until free.
module flow_stats_table_classifier (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [15:0] ether_type, [23:16] ip_protocol, [55:24] source_address,
  // [71:56] packet_length, [135:72] arrival_time
  input  logic [135:0] s_tdata,
  // [0] truncated
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] flow_flag, [32:1] packet_count, [64:33] byte_count,
  // [80:65] largest_size, [96:81] second_largest_size,
  // [112:97] smallest_size, [176:113] longest_gap, [183:177] zero
  output logic [183:0] m_tdata,
  // [1:0] status
  output logic [1:0]   m_tuser
);

  fstc_pkg::item_t   item;
  fstc_pkg::cmd_t    cmd;
  fstc_pkg::stat_t   stat;
  fstc_pkg::result_t res;

  // Unpack the input beat.
  always_comb begin
    item.ether_type     = s_tdata[15:0];
    item.ip_protocol    = s_tdata[23:16];
    item.source_address = s_tdata[55:24];
    item.packet_length  = s_tdata[71:56];
    item.arrival_time   = s_tdata[135:72];
    item.truncated      = s_tuser;
  end

  fstc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fstc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // Pack the result beat.
  assign m_tuser = res.status;
  assign m_tdata = {7'd0, res.longest_gap, res.smallest_size, res.second_largest_size,
                    res.largest_size, res.byte_count, res.packet_count, res.flow_flag};

endmodule
